// File: design/afts_pkg.sv
// Package for the sorted address frequency table.
// Holds sizes, item structs, cell entry and command types, and opcodes.
// No dependencies.
package afts_pkg;

  localparam int TableDepth = 64;
  localparam int AddrW      = 31;
  localparam int CountW     = 32;
  localparam int TotalW     = 7;

  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_DUMP   = 1'b1;

  typedef struct packed {
    logic             op;
    logic [AddrW-1:0] address;
  } in_item_t;

  typedef struct packed {
    logic [CountW-1:0] hit_count;
    logic [AddrW-1:0]  entry_address;
    logic [TotalW-1:0] distinct_total;
    logic              overflowed;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic              valid;
    logic [AddrW-1:0]  address;
    logic [CountW-1:0] count;
  } entry_t;

  // Broadcast to every cell of the chain in each cycle.
  typedef struct packed {
    logic             record;
    logic             hit;
    logic             insert;
    logic             rotate;
    logic [AddrW-1:0] address;
    entry_t           head;
  } cell_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DUMP = 2'b10
  } state_e;

endpackage

// File: design/address_frequency_table_sorted.sv
// Top level of the sorted address frequency table: chain of afts_cell,
// control and output register. Uses afts_pkg and afts_cell.
//
// For a record item, every cell compares its address with
// the incoming one at once, a hit bumps that cell's count (saturating) and a
// miss shifts the higher entries up one cell and drops the new entry in
// place, so a record item can be accepted in every cycle. A dump item of a
// table with N entries gives N result items, one per cycle while the output
// side takes them: the chain rotates one cell toward the head per item, so
// after the dump the table is back where it started. No item is accepted
// while a dump runs; a dump of an empty table finishes in the cycle it is
// accepted. Overflow is sticky until reset.
module address_frequency_table_sorted (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  afts_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output afts_pkg::out_item_t out_item_o
);

  localparam int Depth = afts_pkg::TableDepth;

  afts_pkg::entry_t               ent [Depth];
  logic [Depth-1:0]               ge;
  logic [Depth-1:0]               eq;
  afts_pkg::cell_cmd_t            cmd;

  afts_pkg::state_e               state_q, state_d;
  logic [afts_pkg::TotalW-1:0]    count_q, count_d;
  logic [afts_pkg::TotalW-1:0]    remain_q, remain_d;
  logic                           ovf_q, ovf_d;
  logic                           out_valid_q, out_valid_d;
  afts_pkg::out_item_t            out_q, out_d;

  logic accept, record, hit, full, step;

  assign in_ready_o = (state_q == afts_pkg::ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign record     = accept && (in_item_i.op == afts_pkg::OP_RECORD);
  assign hit        = |eq;
  assign full       = (count_q == afts_pkg::TotalW'(Depth));
  assign step       = (state_q == afts_pkg::ST_DUMP) && (!out_valid_q || out_ready_i);

  always_comb begin
    cmd.record  = record;
    cmd.hit     = hit;
    cmd.insert  = !full;
    cmd.rotate  = step;
    cmd.address = in_item_i.address;
    cmd.head    = ent[0];
  end

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    afts_pkg::entry_t left, right;
    logic             left_ge;
    if (i == 0) begin : g_head
      assign left    = '0;
      assign left_ge = 1'b0;
    end else begin : g_mid
      assign left    = ent[i-1];
      assign left_ge = ge[i-1];
    end
    if (i == Depth - 1) begin : g_tail
      assign right = '0;
    end else begin : g_body
      assign right = ent[i+1];
    end
    afts_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cmd_i     (cmd),
      .left_i    (left),
      .left_ge_i (left_ge),
      .right_i   (right),
      .entry_o   (ent[i]),
      .ge_o      (ge[i]),
      .eq_o      (eq[i])
    );
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    remain_d    = remain_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      afts_pkg::ST_IDLE: begin
        if (record && !hit) begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            count_d = count_q + afts_pkg::TotalW'(1);
          end
        end else if (accept && (in_item_i.op == afts_pkg::OP_DUMP) &&
                     (count_q != '0)) begin
          remain_d = count_q;
          state_d  = afts_pkg::ST_DUMP;
        end
      end
      afts_pkg::ST_DUMP: begin
        if (step) begin
          out_valid_d          = 1'b1;
          out_d.hit_count      = ent[0].count;
          out_d.entry_address  = ent[0].address;
          out_d.distinct_total = count_q;
          out_d.overflowed     = ovf_q;
          out_d.last           = (remain_q == afts_pkg::TotalW'(1));
          remain_d             = remain_q - afts_pkg::TotalW'(1);
          if (remain_q == afts_pkg::TotalW'(1)) begin
            state_d = afts_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = afts_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= afts_pkg::ST_IDLE;
      count_q     <= '0;
      remain_q    <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      remain_q    <= remain_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// File: design/afts_cell.sv
// One cell of the sorted table chain: holds one entry, compares it with
// the broadcast address and shifts in from either neighbour. Uses afts_pkg.
module afts_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  afts_pkg::cell_cmd_t cmd_i,
  input  afts_pkg::entry_t    left_i,
  input  logic                left_ge_i,
  input  afts_pkg::entry_t    right_i,
  output afts_pkg::entry_t    entry_o,
  output logic                ge_o,
  output logic                eq_o
);

  logic                         valid_q, valid_d;
  logic [afts_pkg::AddrW-1:0]   addr_q, addr_d;
  logic [afts_pkg::CountW-1:0]  count_q, count_d;

  always_comb begin
    ge_o = !(valid_q && (addr_q < cmd_i.address));
    eq_o = valid_q && (addr_q == cmd_i.address);
  end

  always_comb begin
    valid_d = valid_q;
    addr_d  = addr_q;
    count_d = count_q;
    if (cmd_i.record) begin
      if (cmd_i.hit) begin
        if (eq_o && (count_q != {afts_pkg::CountW{1'b1}})) begin
          count_d = count_q + afts_pkg::CountW'(1);
        end
      end else if (cmd_i.insert && ge_o) begin
        if (left_ge_i) begin
          // make room: take the lower neighbour's entry
          valid_d = left_i.valid;
          addr_d  = left_i.address;
          count_d = left_i.count;
        end else begin
          valid_d = 1'b1;
          addr_d  = cmd_i.address;
          count_d = afts_pkg::CountW'(1);
        end
      end
    end else if (cmd_i.rotate && valid_q) begin
      // advance toward the head; the tail takes the head entry back
      if (right_i.valid) begin
        addr_d  = right_i.address;
        count_d = right_i.count;
      end else begin
        addr_d  = cmd_i.head.address;
        count_d = cmd_i.head.count;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q  <= addr_d;
    count_q <= count_d;
  end

  assign entry_o = '{valid: valid_q, address: addr_q, count: count_q};

endmodule
